### hdl/doq_pkg.sv
// Package for the deadline-ordered ready queue: sizes, codes, entry and
// control structs, and the ring address helper. No dependencies.
`default_nettype none

package doq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 5;
  localparam int DL_W        = 32;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_YIELD  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
  } entry_t;

  typedef struct packed {
    mode_e  mode;
    entry_t ent;
  } cmd_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             popped_valid;
    logic [ID_W-1:0]  popped_id;
    logic [DL_W-1:0]  popped_dl;
    status_e          status;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  // Ring address of logical position idx, counted from the head.
  function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/doq_if.sv
// Valid/ready channel interfaces for the ready queue: command in, result out.
// Depends on doq_pkg for field widths.
`default_nettype none

interface doq_in_if import doq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   task_id;
  logic [DL_W-1:0]   deadline;

  modport source (output valid, mode, task_id, deadline, input ready);
  modport sink   (input valid, mode, task_id, deadline, output ready);
endinterface

interface doq_out_if import doq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                popped_valid;
  logic [ID_W-1:0]     popped_task_id;
  logic [DL_W-1:0]     popped_deadline;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, popped_valid, popped_task_id, popped_deadline, status,
                  occupancy, input ready);
  modport sink   (input valid, popped_valid, popped_task_id, popped_deadline, status,
                  occupancy, output ready);
endinterface

`default_nettype wire

### hdl/doq_ram.sv
// Entry store of the ready queue: one write port, one registered read port.
// Depends on doq_pkg.
`default_nettype none

module doq_ram import doq_pkg::*; (
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output entry_t        rdata_o
);

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/doq_ctrl.sv
// Sequencer of the ready queue: ring head and count, pop from the head,
// sorted insert by a backward scan that shifts one entry per cycle.
// Depends on doq_pkg; drives doq_ram through a mem_req_t.
`default_nettype none

module doq_ctrl import doq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_valid_i,
  input  wire cmd_t    req_i,
  output logic         req_ready_o,
  output logic         res_valid_o,
  output result_t      res_o,
  input  wire logic    res_ready_i,
  output mem_req_t     mem_req_o,
  input  wire entry_t  mem_rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRNEW = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  cmd_t             cmd_q, cmd_d;
  result_t          res_q, res_d;

  logic             ins_start;
  logic [CNT_W-1:0] ins_n;
  entry_t           ins_ent;
  logic [IDX_W-1:0] scan_j;
  logic             scan_shift;

  assign scan_j     = idx_q - IDX_W'(1);
  // Position zero moves only on a strictly later deadline, the rest on equal too.
  assign scan_shift = (scan_j != '0) ? (mem_rdata_i.dl >= cmd_q.ent.dl)
                                     : (mem_rdata_i.dl >  cmd_q.ent.dl);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    mem_req_o   = '0;
    ins_start   = 1'b0;
    ins_n       = count_q;
    ins_ent     = cmd_q.ent;
    req_ready_o = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_d = req_i;
          res_d = '0;
          unique case (req_i.mode)
            MODE_INSERT: begin
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                res_d.status = ST_FULL;
                state_d      = S_DONE;
              end else begin
                ins_start = 1'b1;
                ins_n     = count_q;
                ins_ent   = req_i.ent;
              end
            end
            MODE_POP, MODE_YIELD: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
                state_d      = S_DONE;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = head_q;
                state_d         = S_POP;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_POP: begin
        res_d.popped_valid = 1'b1;
        res_d.popped_id    = mem_rdata_i.id;
        res_d.popped_dl    = mem_rdata_i.dl;
        head_d             = ring_addr(head_q, IDX_W'(1));
        count_d            = count_q - CNT_W'(1);
        if (cmd_q.mode == MODE_YIELD) begin
          ins_start = 1'b1;
          ins_n     = count_q - CNT_W'(1);
          ins_ent   = cmd_q.ent;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        mem_req_o.we = 1'b1;
        if (scan_shift) begin
          // Move the entry one place toward the tail; fetch the next one down unless position zero moved.
          mem_req_o.waddr = ring_addr(head_q, idx_q);
          mem_req_o.wdata = mem_rdata_i;
          idx_d           = scan_j;
          if (scan_j == '0) begin
            state_d = S_WRNEW;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = ring_addr(head_q, scan_j - IDX_W'(1));
          end
        end else begin
          mem_req_o.waddr = ring_addr(head_q, idx_q);
          mem_req_o.wdata = cmd_q.ent;
          count_d         = count_q + CNT_W'(1);
          state_d         = S_DONE;
        end
      end
      S_WRNEW: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ring_addr(head_q, idx_q);
        mem_req_o.wdata = cmd_q.ent;
        count_d         = count_q + CNT_W'(1);
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ins_start) begin
      if (ins_n == '0) begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = head_d;
        mem_req_o.wdata = ins_ent;
        count_d         = count_d + CNT_W'(1);
        state_d         = S_DONE;
      end else begin
        // Start the scan at the tail entry.
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = ring_addr(head_d, IDX_W'(ins_n - CNT_W'(1)));
        idx_d           = IDX_W'(ins_n);
        state_d         = S_SCAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o           = res_q;
    res_o.occupancy = OCC_W'(count_q);
  end

endmodule

`default_nettype wire

### hdl/deadline_ordered_ready_queue_core.sv
// Earliest-deadline-first ready queue, one result beat per command beat.
// A pop reads the head entry. An insert scans back from the tail, moving each entry
// that must follow the new one a place toward the tail (at most QUEUE_DEPTH - 1 of them),
// and writes straight in when the queue is empty; a yield pops, then inserts.
// Throughput set by the single entry RAM: one entry read and shifted per cycle.
// The output register holds a result beat while the next command runs. Reset empties the
// queue at once.
`default_nettype none

module deadline_ordered_ready_queue_core import doq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  doq_in_if.sink    in_i,
  doq_out_if.source out_o
);

  cmd_t     cmd;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  mem_req_t mem_req;
  entry_t   mem_rdata;
  logic     out_valid_q;
  result_t  out_q;

  assign cmd.mode   = mode_e'(in_i.mode);
  assign cmd.ent.id = in_i.task_id;
  assign cmd.ent.dl = in_i.deadline;

  doq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_i       (cmd),
    .req_ready_o (in_i.ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  doq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.popped_valid    = out_q.popped_valid;
  assign out_o.popped_task_id  = out_q.popped_id;
  assign out_o.popped_deadline = out_q.popped_dl;
  assign out_o.status          = out_q.status;
  assign out_o.occupancy       = out_q.occupancy;

endmodule

`default_nettype wire
